// ----- hdl/ipid_pkg.sv -----
// ipid_pkg: shared constants, types and register codes for the incremental pid controller
// no dependencies
`timescale 1ns / 1ps
package ipid_pkg;
	localparam int ValueWidth = 32;
	localparam int FracBits = 16;
	localparam int CfgWidth = 32;
	localparam int CoefWidth = 48;
	localparam int ErrWidth = ValueWidth + 1;
	localparam int RatioWidth = CfgWidth + FracBits;
	localparam int ProdWidth = CoefWidth + ErrWidth;
	localparam int AccWidth = ProdWidth + 2;

	localparam logic [2:0] RegGainP = 3'd0;
	localparam logic [2:0] RegIntegralTime = 3'd1;
	localparam logic [2:0] RegDerivativeTime = 3'd2;
	localparam logic [2:0] RegSamplePeriod = 3'd3;
	localparam logic [2:0] RegSetpoint = 3'd4;
	localparam logic [2:0] RegUpperBound = 3'd5;
	localparam logic [2:0] RegLowerBound = 3'd6;
	localparam logic [2:0] RegLimitMode = 3'd7;

	localparam logic [1:0] LimUpper = 2'b01;
	localparam logic [1:0] LimLower = 2'b10;

	typedef struct packed {
		logic start;
		logic [RatioWidth-1:0] dividend;
		logic [CfgWidth-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [RatioWidth-1:0] quotient;
	} div_rsp_t;
endpackage

// ----- hdl/ipid_div.sv -----
// ipid_div: restoring divider, one quotient bit per cycle
// depends on ipid_pkg
`timescale 1ns / 1ps
module ipid_div (
	input  logic clk,
	input  logic arst_n,
	input  ipid_pkg::div_req_t req,
	output ipid_pkg::div_rsp_t rsp
);
	localparam int NW = ipid_pkg::RatioWidth;
	localparam int DW = ipid_pkg::CfgWidth;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DW:0] trial;
	logic [DW+1:0] diff;

	// shift in next dividend bit and try subtracting
	always_comb begin
		trial = {rem_q[DW-1:0], quo_q[NW-1]};
		diff = {1'b0, trial} - {2'b00, dsr_q};
	end

	// sequencer for the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule

// ----- hdl/incremental_pid_controller.sv -----
// incremental_pid_controller: top level, register file, sequencer and shared multiplier
// depends on ipid_pkg and ipid_div
`timescale 1ns / 1ps
// Velocity-form PID in signed Q16.16. One measured sample in, one drive value out.
// All multiplies go through one shift-add multiplier that takes 16 bits of one operand
// per cycle, and each multiply holds the sequencer. When the coefficients are current,
// a sample goes through three error multiplies and then the sum, saturation and
// limiter before out_valid rises. After a write to gain_p, integral_time,
// derivative_time or sample_period (and after reset) the next sample first goes
// through two 48-step divisions in the shared divider and three coefficient
// multiplies. The block takes no new sample until the result has been transferred
// and is back in idle the cycle after.
module incremental_pid_controller (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [ipid_pkg::ValueWidth-1:0] measured,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [ipid_pkg::ValueWidth-1:0] drive,
	output logic clipped,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [ipid_pkg::CfgWidth-1:0] cfg_wdata
);
	localparam int VW = ipid_pkg::ValueWidth;
	localparam int FB = ipid_pkg::FracBits;
	localparam int CW = ipid_pkg::CfgWidth;
	localparam int KW = ipid_pkg::CoefWidth;
	localparam int EW = ipid_pkg::ErrWidth;
	localparam int RW = ipid_pkg::RatioWidth;
	localparam int AW = ipid_pkg::AccWidth;
	localparam int SW = RW + 2;
	localparam int MD = 16;
	localparam int MB = ((EW + MD - 1) / MD) * MD;
	localparam int MS = MB / MD;
	localparam int MCW = $clog2(MS + 1);
	localparam int MP = SW + MB;

	localparam logic [3:0] StIdle = 4'd0;
	localparam logic [3:0] StDivI = 4'd1;
	localparam logic [3:0] StWaitI = 4'd2;
	localparam logic [3:0] StDivD = 4'd3;
	localparam logic [3:0] StWaitD = 4'd4;
	localparam logic [3:0] StCoef0 = 4'd5;
	localparam logic [3:0] StCoef1 = 4'd6;
	localparam logic [3:0] StCoef2 = 4'd7;
	localparam logic [3:0] StMac0 = 4'd8;
	localparam logic [3:0] StMac1 = 4'd9;
	localparam logic [3:0] StMac2 = 4'd10;
	localparam logic [3:0] StSum = 4'd11;
	localparam logic [3:0] StOut = 4'd12;

	logic [CW-1:0] gain_q, ti_q, td_q, ts_q;
	logic signed [VW-1:0] setpoint_q, upper_q, lower_q;
	logic [1:0] mode_q;
	logic stale_q;
	logic [3:0] state_q;
	logic signed [VW-1:0] last_q;
	logic signed [EW-1:0] err_q, eprev_q, eprev2_q;
	logic signed [KW-1:0] c0_q, c1_q, c2_q;
	logic [RW-1:0] ri_q, rd_q;
	logic signed [AW-1:0] acc_q;
	logic signed [VW-1:0] drive_q;
	logic clip_q;
	logic cfg_coef_wr;
	logic [CW-1:0] ts_eff;
	ipid_pkg::div_req_t dreq;
	ipid_pkg::div_rsp_t drsp;

	// shared multiplier operands, state and result
	logic mul_op, mul_start;
	logic [SW-1:0] mul_a;
	logic [MB-1:0] mul_b;
	logic [SW-1:0] mul_a_q;
	logic [MP-1:0] mul_p_q;
	logic [MCW-1:0] mul_cnt_q;
	logic mul_busy_q, mul_done_q, mul_go_q;
	logic [SW+MD-1:0] mul_step;
	logic [MP-FB-1:0] mul_shift;
	logic signed [KW-1:0] mac_c;
	logic signed [EW-1:0] mac_e;
	logic [KW-1:0] c_abs;
	logic [EW-1:0] e_abs;
	logic mac_neg;
	logic signed [AW-1:0] mac_term;
	logic [SW-1:0] coef_sum;
	logic [KW-1:0] coef_mag;
	logic signed [AW-1:0] acc_sh;
	logic signed [AW-1:0] sum_full;
	logic signed [VW-1:0] sat_val, lim_val;
	logic sat_clip, lim_clip;

	assign ts_eff = (ts_q == '0) ? CW'(1) : ts_q;
	assign cfg_coef_wr = cfg_we && (cfg_index == ipid_pkg::RegGainP ||
		cfg_index == ipid_pkg::RegIntegralTime || cfg_index == ipid_pkg::RegDerivativeTime ||
		cfg_index == ipid_pkg::RegSamplePeriod);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= CW'(1) << FB;
			ti_q <= '0;
			td_q <= '0;
			ts_q <= CW'(1);
			setpoint_q <= '0;
			upper_q <= {1'b0, {(VW-1){1'b1}}};
			lower_q <= {1'b1, {(VW-1){1'b0}}};
			mode_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ipid_pkg::RegGainP: gain_q <= cfg_wdata;
				ipid_pkg::RegIntegralTime: ti_q <= cfg_wdata;
				ipid_pkg::RegDerivativeTime: td_q <= cfg_wdata;
				ipid_pkg::RegSamplePeriod: ts_q <= cfg_wdata;
				ipid_pkg::RegSetpoint: setpoint_q <= cfg_wdata[VW-1:0];
				ipid_pkg::RegUpperBound: upper_q <= cfg_wdata[VW-1:0];
				ipid_pkg::RegLowerBound: lower_q <= cfg_wdata[VW-1:0];
				ipid_pkg::RegLimitMode: mode_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// divider requests
	always_comb begin
		dreq.start = (state_q == StDivI) || (state_q == StDivD);
		if (state_q == StDivI) begin
			dreq.dividend = RW'(ts_eff) << FB;
			dreq.divisor = ti_q;
		end else begin
			dreq.dividend = RW'(td_q) << FB;
			dreq.divisor = ts_eff;
		end
	end

	ipid_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	// coefficient sums in Q.F
	always_comb begin
		case (state_q)
			StCoef0: coef_sum = (SW'(1) << FB) + SW'(ri_q) + SW'(rd_q);
			StCoef1: coef_sum = (SW'(1) << FB) + (SW'(rd_q) << 1);
			default: coef_sum = SW'(rd_q);
		endcase
	end

	// error product operands as sign and magnitude
	always_comb begin
		case (state_q)
			StMac1: begin
				mac_c = c1_q;
				mac_e = eprev_q;
			end
			StMac2: begin
				mac_c = c2_q;
				mac_e = eprev2_q;
			end
			default: begin
				mac_c = c0_q;
				mac_e = err_q;
			end
		endcase
		mac_neg = mac_c[KW-1] ^ mac_e[EW-1];
		c_abs = mac_c[KW-1] ? -mac_c : mac_c;
		e_abs = mac_e[EW-1] ? -mac_e : mac_e;
	end

	// shared multiplier operands: kp times sum, or coefficient times error
	always_comb begin
		mul_op = (state_q inside {StCoef0, StCoef1, StCoef2, StMac0, StMac1, StMac2});
		mul_start = mul_op && !mul_go_q;
		if (state_q inside {StCoef0, StCoef1, StCoef2}) begin
			mul_a = coef_sum;
			mul_b = MB'(gain_q);
		end else begin
			mul_a = SW'(c_abs);
			mul_b = MB'(e_abs);
		end
	end

	// shift-add step: 16 bits of the second operand per cycle
	assign mul_step = {{MD{1'b0}}, mul_p_q[MP-1:MB]} +
		({{MD{1'b0}}, mul_a_q} * {{SW{1'b0}}, mul_p_q[MD-1:0]});

	// multiplier control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_done_q <= 1'b0;
			mul_go_q <= 1'b0;
			mul_cnt_q <= '0;
		end else begin
			mul_done_q <= 1'b0;
			if (mul_start) begin
				mul_go_q <= 1'b1;
				mul_busy_q <= 1'b1;
				mul_cnt_q <= MCW'(MS);
			end else if (mul_busy_q) begin
				mul_cnt_q <= mul_cnt_q - 1'b1;
				if (mul_cnt_q == MCW'(1)) begin
					mul_busy_q <= 1'b0;
					mul_done_q <= 1'b1;
				end
			end else if (mul_done_q) begin
				mul_go_q <= 1'b0;
			end
		end
	end

	// multiplier datapath
	always_ff @(posedge clk) begin
		if (mul_start) begin
			mul_a_q <= mul_a;
			mul_p_q <= {{SW{1'b0}}, mul_b};
		end else if (mul_busy_q) begin
			mul_p_q <= {mul_step, mul_p_q[MB-1:MD]};
		end
	end

	// saturated coefficient magnitude and signed error product
	assign mul_shift = mul_p_q[MP-1:FB];
	assign coef_mag = (mul_shift > (MP-FB)'({1'b0, {(KW-1){1'b1}}}))
		? {1'b0, {(KW-1){1'b1}}} : mul_shift[KW-1:0];
	assign mac_term = mac_neg ? -AW'(mul_p_q) : AW'(mul_p_q);

	// final sum, saturation and limiter
	always_comb begin
		acc_sh = acc_q >>> FB;
		sum_full = acc_sh + AW'(last_q);
		sat_clip = 1'b0;
		if (sum_full > AW'($signed({1'b0, {(VW-1){1'b1}}}))) begin
			sat_val = {1'b0, {(VW-1){1'b1}}};
			sat_clip = 1'b1;
		end else if (sum_full < AW'($signed({1'b1, {(VW-1){1'b0}}}))) begin
			sat_val = {1'b1, {(VW-1){1'b0}}};
			sat_clip = 1'b1;
		end else begin
			sat_val = sum_full[VW-1:0];
		end
		lim_clip = 1'b0;
		lim_val = sat_val;
		if ((mode_q & ipid_pkg::LimUpper) != '0 && sat_val > upper_q) begin
			lim_val = upper_q;
			lim_clip = 1'b1;
		end else if ((mode_q & ipid_pkg::LimLower) != '0 && sat_val < lower_q) begin
			lim_val = lower_q;
			lim_clip = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			stale_q <= 1'b1;
			last_q <= '0;
			eprev_q <= '0;
			eprev2_q <= '0;
		end else begin
			if (cfg_coef_wr)
				stale_q <= 1'b1;
			else if (state_q == StCoef2 && mul_done_q)
				stale_q <= 1'b0;
			case (state_q)
				StIdle: begin
					if (in_valid) begin
						state_q <= stale_q ? StDivI : StMac0;
					end
				end
				StDivI: state_q <= StWaitI;
				StWaitI: if (drsp.done) state_q <= StDivD;
				StDivD: state_q <= StWaitD;
				StWaitD: if (drsp.done) state_q <= StCoef0;
				StCoef0: if (mul_done_q) state_q <= StCoef1;
				StCoef1: if (mul_done_q) state_q <= StCoef2;
				StCoef2: if (mul_done_q) state_q <= StMac0;
				StMac0: if (mul_done_q) state_q <= StMac1;
				StMac1: if (mul_done_q) state_q <= StMac2;
				StMac2: if (mul_done_q) state_q <= StSum;
				StSum: begin
					state_q <= StOut;
					last_q <= lim_val;
					eprev2_q <= eprev_q;
					eprev_q <= err_q;
				end
				StOut: if (!out_stall) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == StIdle && in_valid)
			err_q <= EW'(setpoint_q) - EW'(measured);
		if (state_q == StWaitI && drsp.done)
			ri_q <= (ti_q == '0) ? '0 : drsp.quotient;
		if (state_q == StWaitD && drsp.done)
			rd_q <= drsp.quotient;
		if (mul_done_q) begin
			case (state_q)
				StCoef0: c0_q <= coef_mag;
				StCoef1: c1_q <= -coef_mag;
				StCoef2: c2_q <= coef_mag;
				StMac0: acc_q <= mac_term;
				StMac1, StMac2: acc_q <= acc_q + mac_term;
				default: ;
			endcase
		end
		if (state_q == StSum) begin
			drive_q <= lim_val;
			clip_q <= sat_clip | lim_clip;
		end
	end

	assign in_stall = (state_q != StIdle);
	assign out_valid = (state_q == StOut);
	assign drive = drive_q;
	assign clipped = clip_q;

	// a result is offered only after its sum was formed
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == StSum)
		else $error("result without sum");
	// no sample enters while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");
	// coefficients are fresh before any multiply-accumulate
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StMac0) |-> !stale_q)
		else $error("stale coefficients used");
endmodule

// ----- verif/ipid_checker.sv -----
// ipid_checker: watches the sample, result and register ports of the pid controller,
// predicts each drive value and compares it; depends on ipid_pkg
`timescale 1ns / 1ps
module ipid_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [ipid_pkg::ValueWidth-1:0] measured,
	input  logic out_valid,
	input  logic out_stall,
	input  logic signed [ipid_pkg::ValueWidth-1:0] drive,
	input  logic clipped,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [ipid_pkg::CfgWidth-1:0] cfg_wdata,
	output int errors,
	output int pending
);
	localparam int ValueWidth = ipid_pkg::ValueWidth;
	localparam int CfgWidth = ipid_pkg::CfgWidth;
	localparam int ErrWidth = ipid_pkg::ErrWidth;
	localparam int CoefWidth = ipid_pkg::CoefWidth;
	localparam int FracBits = ipid_pkg::FracBits;
	localparam logic [127:0] CoefMax = (128'd1 << 47) - 128'd1;

	typedef struct packed {
		logic signed [ValueWidth-1:0] drive;
		logic clipped;
	} drive_result_t;

	drive_result_t drive_q[$];

	// shadow of the register file
	logic [CfgWidth-1:0] kp, ti, td, ts;
	logic signed [ValueWidth-1:0] sp, ub, lb;
	logic [1:0] mode;

	// controller state
	logic signed [ValueWidth-1:0] last_drive;
	logic signed [ErrWidth-1:0] err1, err2;
	logic signed [CoefWidth-1:0] c0, c1, c2;
	logic stale;

	// floor(k * s / 2^F), saturated to the coefficient range
	function automatic logic [CoefWidth-1:0] coef_mag(logic [CfgWidth-1:0] k, logic [63:0] s);
		logic [127:0] p;
		p = ({96'd0, k} * {64'd0, s}) >> FracBits;
		if (p > CoefMax)
			return CoefMax[CoefWidth-1:0];
		return p[CoefWidth-1:0];
	endfunction

	function automatic void refresh_coefs();
		logic [63:0] period, ri, rd;
		period = (ts == 0) ? 64'd1 : {32'd0, ts};
		ri = (ti != 0) ? (period << FracBits) / {32'd0, ti} : 64'd0;
		rd = ({32'd0, td} << FracBits) / period;
		c0 = coef_mag(kp, (64'd1 << FracBits) + ri + rd);
		c1 = -coef_mag(kp, (64'd1 << FracBits) + 2 * rd);
		c2 = coef_mag(kp, rd);
		stale = 1'b0;
	endfunction

	// one sample through the velocity-form update, state advanced
	function automatic drive_result_t next_drive(logic signed [ValueWidth-1:0] m);
		logic signed [ErrWidth-1:0] e;
		logic signed [127:0] a0, a1, a2, b0, b1, b2, acc, prev;
		logic signed [127:0] hi_lim, lo_lim;
		logic signed [ValueWidth-1:0] d;
		drive_result_t r;
		if (stale)
			refresh_coefs();
		e = ErrWidth'(sp) - ErrWidth'(m);
		a0 = c0;
		a1 = c1;
		a2 = c2;
		b0 = e;
		b1 = err1;
		b2 = err2;
		prev = last_drive;
		hi_lim = 128'sd2147483647;
		lo_lim = -128'sd2147483648;
		acc = ((a0 * b0 + a1 * b1 + a2 * b2) >>> FracBits) + prev;
		r.clipped = 1'b0;
		if (acc > hi_lim) begin
			d = {1'b0, {(ValueWidth-1){1'b1}}};
			r.clipped = 1'b1;
		end else if (acc < lo_lim) begin
			d = {1'b1, {(ValueWidth-1){1'b0}}};
			r.clipped = 1'b1;
		end else begin
			d = acc[ValueWidth-1:0];
		end
		// limiter: upper test wins when the bounds cross
		if ((mode & ipid_pkg::LimUpper) != 0 && d > ub) begin
			d = ub;
			r.clipped = 1'b1;
		end else if ((mode & ipid_pkg::LimLower) != 0 && d < lb) begin
			d = lb;
			r.clipped = 1'b1;
		end
		r.drive = d;
		last_drive = d;
		err2 = err1;
		err1 = e;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_result_t want;
		if (!arst_n) begin
			kp = 32'h0001_0000;
			ti = '0;
			td = '0;
			ts = 32'd1;
			sp = '0;
			ub = {1'b0, {(ValueWidth-1){1'b1}}};
			lb = {1'b1, {(ValueWidth-1){1'b0}}};
			mode = '0;
			last_drive = '0;
			err1 = '0;
			err2 = '0;
			c0 = '0;
			c1 = '0;
			c2 = '0;
			stale = 1'b1;
			drive_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					ipid_pkg::RegGainP: begin kp = cfg_wdata; stale = 1'b1; end
					ipid_pkg::RegIntegralTime: begin ti = cfg_wdata; stale = 1'b1; end
					ipid_pkg::RegDerivativeTime: begin td = cfg_wdata; stale = 1'b1; end
					ipid_pkg::RegSamplePeriod: begin ts = cfg_wdata; stale = 1'b1; end
					ipid_pkg::RegSetpoint: sp = cfg_wdata;
					ipid_pkg::RegUpperBound: ub = cfg_wdata;
					ipid_pkg::RegLowerBound: lb = cfg_wdata;
					ipid_pkg::RegLimitMode: mode = cfg_wdata[1:0];
					default: ;
				endcase
			end
			// result transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				if (drive_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: result with nothing pending: drive %0d clipped %0b",
							drive, clipped);
				end else begin
					want = drive_q.pop_front();
					if (drive !== want.drive || clipped !== want.clipped) begin
						errors++;
						if (errors <= 10)
							$display("ERROR: drive exp %0d got %0d, clipped exp %0b got %0b",
								want.drive, drive, want.clipped, clipped);
					end
				end
			end
			// sample transfer
			if (in_valid && !in_stall)
				drive_q.push_back(next_drive(measured));
			pending = drive_q.size();
		end
	end
endmodule

// ----- verif/tb_incremental_pid_controller.sv -----
// tb_incremental_pid_controller: stimulus, register programming and verdict for the pid
// controller; depends on ipid_pkg, incremental_pid_controller and ipid_checker
`timescale 1ns / 1ps
module tb_incremental_pid_controller;
	localparam int CycleLimit = 2000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [ipid_pkg::ValueWidth-1:0] measured;
	logic out_valid;
	logic out_stall;
	logic signed [ipid_pkg::ValueWidth-1:0] drive;
	logic clipped;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [ipid_pkg::CfgWidth-1:0] cfg_wdata;
	int errors;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int cycles;
	int samples;
	int settings;
	logic signed [ipid_pkg::ValueWidth-1:0] cur_sp;

	incremental_pid_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.measured(measured),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive(drive),
		.clipped(clipped),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	ipid_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.measured(measured),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive(drive),
		.clipped(clipped),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.errors(errors),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver stalls at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// one sample transfer, with an optional idle gap in front
	task automatic send_sample(logic signed [ipid_pkg::ValueWidth-1:0] m);
		int gap;
		gap = 0;
		if ($urandom_range(99) < send_idle_pct)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		measured <= m;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		samples++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// write all eight registers back to back while the block is idle
	task automatic program_regs(logic [31:0] kp, logic [31:0] ti, logic [31:0] td,
			logic [31:0] ts, logic [31:0] sp, logic [31:0] ub, logic [31:0] lb,
			logic [1:0] mode);
		logic [31:0] vals[8];
		wait_idle();
		vals = '{kp, ti, td, ts, sp, ub, lb, {30'd0, mode}};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_wdata <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_sp = sp;
		settings++;
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return $urandom;
			2: return 32'hFFFF_FFFF;
			default: return $urandom_range(32'h0000_1000, 32'h0004_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_time();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return $urandom;
			2: return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(4))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
		endcase
	endfunction

	// mostly small steps around the setpoint, some full-range samples
	function automatic logic [31:0] pick_sample();
		if ($urandom_range(99) < 70)
			return cur_sp + 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		return $urandom;
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		measured = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cycles = 0;
		samples = 0;
		settings = 0;
		cur_sp = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings with field extremes
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h8000_0000);
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_FFFF);
		// integral and derivative on, full-scale saturation both ways
		program_regs(32'h0002_0000, 32'd1, 32'd1, 32'd1, 32'h0001_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 2'd0);
		send_sample(32'h8000_0000);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		// zero sample period, upper limiter only
		program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000,
			32'h0001_0000, 32'hFFFF_0000, 2'd1);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h0000_0000);
		// lower limiter only
		program_regs(32'h0001_0000, 32'd0, 32'd0, 32'd1, 32'h0000_0000,
			32'h0001_0000, 32'hFFFF_0000, 2'd2);
		send_sample(32'h0004_0000);
		send_sample(32'hFFFF_0000);
		send_sample(32'h0000_0000);
		// both limits with lower above upper, then drive equal to a bound
		program_regs(32'h0001_0000, 32'd0, 32'd0, 32'd1, 32'h0000_0000,
			32'h0001_0000, 32'h0002_0000, 2'd3);
		send_sample(32'hFFFF_8000);
		send_sample(32'h0000_0000);
		send_sample(32'h0003_0000);
		program_regs(32'h0001_0000, 32'd0, 32'd0, 32'd1, 32'h0000_0000,
			32'h0001_0000, 32'hFFFF_0000, 2'd3);
		send_sample(32'hFFFF_0000);
		send_sample(32'h0000_0000);
		send_sample(32'h0001_0000);

		// random part in three idle regimes
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 82 : 0;
			recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 11 : 0;
			for (int s = 0; s < 6; s++) begin
				program_regs(pick_gain(), pick_time(), pick_time(), pick_time(),
					pick_value(), pick_value(), pick_value(), 2'($urandom_range(3)));
				for (int i = 0; i < 52; i++)
					send_sample(pick_sample());
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("run summary: %0d samples over %0d register settings, %0d cycles",
			samples, settings, cycles);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("mismatches: %0d", errors);
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/ipid_pkg.sv
hdl/ipid_div.sv
hdl/incremental_pid_controller.sv
verif/ipid_checker.sv
verif/tb_incremental_pid_controller.sv
